// ===== rtl/wes_pkg.sv =====
// Package for the window edge snap engine: operation codes, CSR indexes,
// widths and reset values. No dependencies.
`timescale 1ns / 1ps
package wes_pkg;
   localparam int TableDepthDefault = 64;
   localparam int FracBitsDefault   = 8;
   localparam int CoordW            = 32;
   localparam int SizeW             = 16;
   localparam int CfgW              = 20;
   localparam int CalcW             = 40;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_MOVE   = 2'd1,
      OP_RESIZE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_DISTANCE = 2'd1,
      CSR_SPACING  = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_type;

   localparam logic [CfgW-1:0] DistanceReset = 20'd2560;
endpackage

// ===== rtl/window_edge_snap_engine.sv =====
// Window edge snap engine top level: window table memory and scan sequencer.
// Depends on wes_pkg.
`timescale 1ns / 1ps
// A write request is stored in the write state. A move or resize query, with
// snapping enabled and an in-range index, reads the queried window, then
// scans the table one entry per cycle through a single memory read port,
// then, if only one axis has a winner, rereads that window for the other
// axis. One request is worked at a time; a finished result waits in the
// output register while the next request is taken. The valid marks clear
// at reset; table entries do not.
module window_edge_snap_engine #(
   parameter int TABLE_DEPTH = wes_pkg::TableDepthDefault,
   parameter int FRAC_BITS   = wes_pkg::FracBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [5:0]                  req_window_index,
   input  logic                        req_entry_valid,
   input  logic signed [31:0]          req_origin_x,
   input  logic signed [31:0]          req_origin_y,
   input  logic [15:0]                 req_size_w,
   input  logic [15:0]                 req_size_h,
   input  logic signed [31:0]          req_delta_x,
   input  logic signed [31:0]          req_delta_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_adjusted_dx,
   output logic signed [31:0]          rsp_adjusted_dy,
   output logic                        rsp_snapped_x,
   output logic                        rsp_snapped_y,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [19:0]                 csr_data
);
   import wes_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = AW + 1;
   localparam int IW = (AW > 6) ? AW : 6;
   localparam int EW = 2 * CoordW + 2 * SizeW;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_WRITE = 7'b0000010,
      S_OWN   = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_RETRY = 7'b0010000,
      S_RTRD  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // configuration
   logic            enable_ff;
   logic [CfgW-1:0] dist_ff, space_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         dist_ff   <= DistanceReset;
         space_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_ENABLE:   enable_ff <= csr_data[0];
            CSR_DISTANCE: dist_ff   <= csr_data;
            CSR_SPACING:  space_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // table memory and valid marks
   logic [EW-1:0]          mem [TABLE_DEPTH];
   logic [EW-1:0]          rd_ff;
   logic [TABLE_DEPTH-1:0] present_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_wa, mem_ra;
   logic [EW-1:0]          mem_wd;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   // request registers
   state_type           state_ff, state_in;
   op_type              op_ff;
   logic [5:0]          idx_ff;
   logic                ent_v_ff;
   logic signed [31:0]  ox_ff, oy_ff, dx_ff, dy_ff;
   logic [15:0]         sw_ff, sh_ff;
   logic [CW-1:0]       cnt_ff;
   logic [CW-1:0]       rd_idx_ff;
   logic                rd_ok_ff;
   logic signed [CalcW-1:0] l_ff, t_ff, r_ff, b_ff, bx_ff, by_ff;
   logic                wxv_ff, wyv_ff;
   logic [AW-1:0]       wx_ff, wy_ff;
   logic                rv_ff;
   logic signed [31:0]  odx_ff, ody_ff;
   logic                osx_ff, osy_ff;

   logic idx_in_range;
   logic [IW-1:0] idx_x;
   assign idx_x = IW'(idx_ff);
   assign idx_in_range = {26'd0, idx_ff} < 32'(TABLE_DEPTH);
   assign req_stall = (state_ff != S_IDLE);

   // fields of the word just read
   logic signed [CalcW-1:0] ol, ot, orr, ob, spc;
   always_comb begin
      ol  = CalcW'($signed(rd_ff[EW-1 -: CoordW]));
      ot  = CalcW'($signed(rd_ff[EW-1-CoordW -: CoordW]));
      orr = ol + (CalcW'(rd_ff[2*SizeW-1 -: SizeW]) <<< FRAC_BITS);
      ob  = ot + (CalcW'(rd_ff[SizeW-1:0]) <<< FRAC_BITS);
      spc = CalcW'(space_ff);
   end

   function automatic logic signed [CalcW-1:0] absv(input logic signed [CalcW-1:0] v);
      absv = v[CalcW-1] ? -v : v;
   endfunction

   // four candidates, resize starts at the third; returns hit and new best
   function automatic logic [CalcW:0] try_axis(
      input logic signed [CalcW-1:0] olo, ohi, lo, hi, sp, best,
      input logic resize);
      logic signed [CalcW-1:0] c [4];
      logic signed [CalcW-1:0] bst;
      logic hit;
      c[0] = olo - lo;
      c[1] = (ohi + sp) - lo;
      c[2] = ohi - hi;
      c[3] = (olo - sp) - hi;
      bst = best;
      hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if ((k >= 2 || !resize) && absv(c[k]) < absv(bst)) begin
            bst = c[k];
            hit = 1'b1;
         end
      end
      try_axis = {hit, bst};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [CalcW-1:0] v);
      if (v > 40'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -40'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   logic [CalcW:0] tx, ty;
   logic           ovy, ovx, use_e;
   always_comb begin
      use_e = rd_ok_ff && (rd_idx_ff[AW-1:0] != idx_x[AW-1:0])
              && present_ff[rd_idx_ff[AW-1:0]];
      ovy = (t_ff < ob) && (b_ff > ot);
      ovx = (l_ff < orr) && (r_ff > ol);
      tx  = try_axis(ol, orr, l_ff, r_ff, spc, bx_ff, op_ff == OP_RESIZE);
      ty  = try_axis(ot, ob, t_ff, b_ff, spc, by_ff, op_ff == OP_RESIZE);
      mem_we = (state_ff == S_WRITE) && (op_ff == OP_WRITE) && idx_in_range;
      mem_wa = idx_x[AW-1:0];
      mem_wd = {ox_ff, oy_ff, sw_ff, sh_ff};
      unique case (state_ff)
         S_OWN, S_SCAN: mem_ra = cnt_ff[AW-1:0];
         S_RETRY:       mem_ra = wxv_ff ? wx_ff : wy_ff;
         default:       mem_ra = idx_x[AW-1:0];
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_WRITE;
         S_WRITE: begin
            if (op_ff == OP_WRITE || op_ff == OP_NONE) state_in = S_IDLE;
            else if (enable_ff && idx_in_range) state_in = S_OWN;
            else state_in = S_DONE;
         end
         S_OWN:   state_in = S_SCAN;
         S_SCAN:  if (cnt_ff == CW'(TABLE_DEPTH)) state_in = S_RETRY;
         S_RETRY: state_in = (wxv_ff != wyv_ff) ? S_RTRD : S_DONE;
         S_RTRD:  state_in = S_DONE;
         S_DONE:  if (!rv_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         present_ff <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mem_we) present_ff[idx_x[AW-1:0]] <= ent_v_ff;
         // result held while stalled, loaded when the slot frees
         rv_ff <= (state_ff == S_DONE && (!rv_ff || !rsp_stall)) || (rv_ff && rsp_stall);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            op_ff    <= op_type'(req_operation);
            idx_ff   <= req_window_index;
            ent_v_ff <= req_entry_valid;
            ox_ff <= req_origin_x;  oy_ff <= req_origin_y;
            sw_ff <= req_size_w;    sh_ff <= req_size_h;
            dx_ff <= req_delta_x;   dy_ff <= req_delta_y;
         end
         S_WRITE: begin
            cnt_ff <= '0;
            bx_ff  <= CalcW'(dist_ff);
            by_ff  <= CalcW'(dist_ff);
            wxv_ff <= 1'b0;
            wyv_ff <= 1'b0;
         end
         S_OWN: begin
            // rd_ff holds the queried window's own entry; entry 0 is read now
            cnt_ff    <= CW'(1);
            rd_idx_ff <= '0;
            rd_ok_ff  <= 1'b1;
            if (op_ff == OP_MOVE) begin
               l_ff <= CalcW'(ox_ff) + CalcW'(dx_ff);
               t_ff <= CalcW'(oy_ff) + CalcW'(dy_ff);
               r_ff <= CalcW'(ox_ff) + CalcW'(dx_ff)
                       + (CalcW'(rd_ff[2*SizeW-1 -: SizeW]) <<< FRAC_BITS);
               b_ff <= CalcW'(oy_ff) + CalcW'(dy_ff)
                       + (CalcW'(rd_ff[SizeW-1:0]) <<< FRAC_BITS);
            end else begin
               l_ff <= ol;
               t_ff <= ot;
               r_ff <= orr + CalcW'(dx_ff);
               b_ff <= ob + CalcW'(dy_ff);
            end
         end
         S_SCAN: begin
            cnt_ff    <= cnt_ff + CW'(1);
            rd_idx_ff <= cnt_ff;
            rd_ok_ff  <= cnt_ff < CW'(TABLE_DEPTH);
            if (use_e) begin
               if (ovy && tx[CalcW]) begin
                  bx_ff <= tx[CalcW-1:0]; wxv_ff <= 1'b1; wx_ff <= rd_idx_ff[AW-1:0];
               end
               if (ovx && ty[CalcW]) begin
                  by_ff <= ty[CalcW-1:0]; wyv_ff <= 1'b1; wy_ff <= rd_idx_ff[AW-1:0];
               end
            end
         end
         S_RETRY: ;
         S_RTRD: begin
            if (wxv_ff && !wyv_ff && ty[CalcW]) begin
               by_ff <= ty[CalcW-1:0]; wyv_ff <= 1'b1;
            end else if (wyv_ff && !wxv_ff && tx[CalcW]) begin
               bx_ff <= tx[CalcW-1:0]; wxv_ff <= 1'b1;
            end
         end
         S_DONE: if (!rv_ff || !rsp_stall) begin
            odx_ff <= wxv_ff ? sat32(CalcW'(dx_ff) + bx_ff) : dx_ff;
            ody_ff <= wyv_ff ? sat32(CalcW'(dy_ff) + by_ff) : dy_ff;
            osx_ff <= wxv_ff;
            osy_ff <= wyv_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_adjusted_dx = odx_ff;
   assign rsp_adjusted_dy = ody_ff;
   assign rsp_snapped_x   = osx_ff;
   assign rsp_snapped_y   = osy_ff;
endmodule
